/* src/lkvc_pkg.sv */
// Package with the sizes and transfer types of the LRU key-value cache.
package lkvc_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CAP_BITS   = 5;
  localparam int SLOT_BITS  = $clog2(ENTRIES);
  localparam int RANK_BITS  = $clog2(ENTRIES);
  localparam int COUNT_BITS = $clog2(ENTRIES + 1);

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(ENTRIES);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] insert_value;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] value;
    logic [SLOT_BITS-1:0]  slot;
    logic                  evicted;
    logic [COUNT_BITS-1:0] entries_used;
  } rsp_t;

endpackage

/* src/lru_key_value_cache_core.sv */
// Fully associative key-value cache with least-recently-used replacement.
//
// A request is held in an input register; once the output register can take it, every stored
// key is compared at once, the hit, free or victim entry is chosen, the rank order is updated
// and the response is written to the output register. One request per cycle is sustained
// while rsp_stall does not hold a response. Recency is held as a rank per entry (0 most
// recent). There is no clearing pass after reset. capacity is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while idle, which the block does not enforce.
module lru_key_value_cache_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  lkvc_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output lkvc_pkg::rsp_t                rsp,
  input  logic                          cfg_wr_en,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wr_data
);
  import lkvc_pkg::*;

  // Control state.
  logic [CAP_BITS-1:0]   capacity;
  logic [ENTRIES-1:0]    entry_valid;
  logic [RANK_BITS-1:0]  rank [ENTRIES];
  logic [COUNT_BITS-1:0] fill_count;
  logic                  req_q_valid;

  // Payload state.
  req_t                  req_q;
  logic [KEY_BITS-1:0]   entry_key   [ENTRIES];
  logic [VALUE_BITS-1:0] entry_value [ENTRIES];

  // Stage logic.
  logic                  advance;
  logic [ENTRIES-1:0]    match;
  logic                  hit_any;
  logic [SLOT_BITS-1:0]  hit_slot;
  logic [SLOT_BITS-1:0]  free_slot;
  logic [SLOT_BITS-1:0]  victim_slot;
  logic [SLOT_BITS-1:0]  target;
  logic [COUNT_BITS-1:0] cap_eff;
  logic                  has_room;
  logic                  do_insert;
  logic                  do_update;
  logic [RANK_BITS-1:0]  target_rank;
  logic [RANK_BITS-1:0]  oldest_rank;
  logic [RANK_BITS-1:0]  rank_next [ENTRIES];
  logic [ENTRIES-1:0]    entry_valid_next;
  logic [COUNT_BITS-1:0] fill_count_next;
  rsp_t                  rsp_next;

  assign advance   = req_q_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = req_q_valid && !advance;

  // Zero acts as one, anything above the entry count acts as the entry count.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = COUNT_BITS'(1);
    end else if (capacity > CAP_RESET) begin
      cap_eff = COUNT_BITS'(ENTRIES);
    end else begin
      cap_eff = COUNT_BITS'(capacity);
    end
  end

  assign oldest_rank = RANK_BITS'(fill_count - COUNT_BITS'(1));

  // Lowest matching, lowest free and the least recent entry. Valid ranks always form a
  // permutation of 0 to fill_count-1, so the victim is the one whose rank is fill_count-1.
  always_comb begin
    hit_slot    = '0;
    free_slot   = '0;
    victim_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = entry_valid[i] && (entry_key[i] == req_q.key);
      if (match[i]) begin
        hit_slot = SLOT_BITS'(i);
      end
      if (!entry_valid[i]) begin
        free_slot = SLOT_BITS'(i);
      end
      if (entry_valid[i] && rank[i] == oldest_rank) begin
        victim_slot = SLOT_BITS'(i);
      end
    end
  end

  assign hit_any   = |match;
  assign has_room  = fill_count < cap_eff;
  assign do_insert = !hit_any && (req_q.opcode == OP_INSERT);
  assign do_update = hit_any || do_insert;

  always_comb begin
    if (hit_any) begin
      target = hit_slot;
    end else if (has_room) begin
      target = free_slot;
    end else begin
      target = victim_slot;
    end
  end

  assign target_rank = rank[target];

  // A hit or an eviction moves down only the entries that were more recent than the target;
  // a fill into a free slot moves down every valid entry.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_next[i] = rank[i];
      if (SLOT_BITS'(i) == target) begin
        rank_next[i] = '0;
      end else if (entry_valid[i] && ((do_insert && has_room) || rank[i] < target_rank)) begin
        rank_next[i] = rank[i] + RANK_BITS'(1);
      end
    end
  end

  always_comb begin
    entry_valid_next = entry_valid;
    fill_count_next  = fill_count;
    if (do_insert) begin
      entry_valid_next[target] = 1'b1;
      if (has_room) begin
        fill_count_next = fill_count + COUNT_BITS'(1);
      end
    end
  end

  always_comb begin
    rsp_next.hit          = hit_any;
    rsp_next.evicted      = do_insert && !has_room;
    rsp_next.entries_used = fill_count_next;
    if (hit_any) begin
      rsp_next.value = entry_value[hit_slot];
    end else if (do_insert) begin
      rsp_next.value = req_q.insert_value;
    end else begin
      rsp_next.value = '0;
    end
    rsp_next.slot = do_update ? target : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_RESET;
      entry_valid <= '0;
      fill_count  <= '0;
      req_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (req_valid && !req_stall) begin
        req_q_valid <= 1'b1;
      end else if (advance) begin
        req_q_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (advance && do_update) begin
        entry_valid <= entry_valid_next;
        fill_count  <= fill_count_next;
        rank        <= rank_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
    if (advance && do_insert) begin
      entry_key[target]   <= req_q.key;
      entry_value[target] <= req_q.insert_value;
    end
  end

  // The fill count always equals the number of valid entries.
  assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(fill_count))
    else $error("fill count differs from the number of valid entries");

  assert property (@(posedge clk) disable iff (rst)
    fill_count <= COUNT_BITS'(ENTRIES))
    else $error("fill count exceeds the entry count");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.hit && rsp.evicted))
    else $error("response reports both a hit and an eviction");

  // A hit or an eviction leaves the number of filled entries unchanged.
  assert property (@(posedge clk) disable iff (rst)
    advance && (hit_any || (do_insert && !has_room)) |=> fill_count == $past(fill_count))
    else $error("fill count changed on a hit or an eviction");

endmodule
